/* design/stt_pkg.sv */
// Package for the session token table: request, status and register codes.
// No dependencies; compiled first.
package stt_pkg;
  localparam logic [2:0] REQ_CREATE = 3'd0;
  localparam logic [2:0] REQ_AUTH   = 3'd1;
  localparam logic [2:0] REQ_GRANT  = 3'd2;
  localparam logic [2:0] REQ_REVOKE = 3'd3;
  localparam logic [2:0] REQ_RVKALL = 3'd4;
  localparam logic [2:0] REQ_QUERY  = 3'd5;

  localparam logic [1:0] GATE_OK      = 2'd0;
  localparam logic [1:0] GATE_NO_SESS = 2'd1;
  localparam logic [1:0] GATE_BAD_CSRF = 2'd2;
  localparam logic [1:0] GATE_NO_GRANT = 2'd3;

  localparam logic [1:0] LVL_WRITE  = 2'd1;
  localparam logic [1:0] LVL_UPDATE = 2'd2;

  localparam logic [1:0] REG_SRC_READY = 2'd0;
  localparam logic [1:0] REG_SESS_LIFE = 2'd1;
  localparam logic [1:0] REG_GRANT_LIFE = 2'd2;

  // ceil(2^38 / 1000): x / 1000 == (x * MS_RECIP) >> 38 for any 32-bit x
  localparam logic [28:0] MS_RECIP = 29'd274877907;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] now_ms;
    logic [31:0] epoch;
    logic        sid_present;
    logic [63:0] sid;
    logic        csrf_present;
    logic [63:0] csrf;
    logic [1:0]  access_level;
    logic [63:0] random_sid;
    logic [63:0] random_csrf;
  } req_t;

  typedef struct packed {
    logic        success;
    logic [1:0]  gate_status;
    logic [63:0] token_out;
    logic [63:0] csrf_out;
    logic [22:0] remaining_s;
    logic        grant_active;
    logic [3:0]  live_count;
  } rsp_t;
endpackage

/* design/stt_req_if.sv */
// Valid/ready channel carrying one session table request.
// Depends on stt_pkg.
interface stt_req_if;
  logic          valid;
  logic          ready;
  stt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/stt_rsp_if.sv */
// Valid/ready channel carrying one session table result.
// Depends on stt_pkg.
interface stt_rsp_if;
  logic          valid;
  logic          ready;
  stt_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/session_token_table_top.sv */
// Session token table: slot storage, reap/search sequencer and APB registers.
// Depends on stt_pkg, stt_req_if and stt_rsp_if.
//
// Usage:
//   req is a valid/ready channel; one request transaction yields exactly one
//   result transaction on rsp. Registers are written through the APB port
//   (0x0 source ready, 0x4 session lifetime, 0x8 grant lifetime).
//   A request runs one reap pass over SLOT_COUNT slots, one search pass over
//   SLOT_COUNT slots through a shared 64-bit compare/subtract unit, then an
//   action step; a query that hits adds a divide step (S_DIV) for the seconds
//   value, a reciprocal multiply by 1/1000. Unknown kinds go straight to the
//   result. req is not ready from acceptance until the result is taken; the
//   result is held in an output register while the receiver stalls.
//   Reset (rst, synchronous) empties every slot and loads register defaults.
module session_token_table_top #(
  parameter int SLOT_COUNT = 8,
  parameter int TOKEN_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  stt_req_if.sink     req,
  stt_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stt_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [63:0] TMASK = {64{1'b1}} >> (64 - TOKEN_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REAP = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_ACT  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic        src_ready;
  logic [31:0] sess_life;
  logic [31:0] grant_life;

  logic [SLOT_COUNT-1:0] used;
  logic [63:0] s_tok [SLOT_COUNT];
  logic [63:0] s_csrf [SLOT_COUNT];
  logic [63:0] s_created [SLOT_COUNT];
  logic [63:0] s_grant [SLOT_COUNT];
  logic [31:0] s_epoch [SLOT_COUNT];

  logic [2:0]    state;
  logic [IW-1:0] idx;
  req_t          r;
  rsp_t          o;
  logic          first_hit, last_hit, free_hit, old_valid;
  logic [IW-1:0] first_idx, last_idx, free_idx, old_idx;
  logic [63:0]   old_time;
  logic [CW-1:0] live;
  logic [SLOT_COUNT-1:0] match;
  logic [31:0]   rem;

  // shared unit: elapsed = now - created[idx]
  logic [63:0] elapsed;
  logic        expired, is_match;
  logic [IW-1:0] act_idx;
  logic [64:0] gsum;
  logic [60:0] dprod;

  assign elapsed  = r.now_ms - s_created[idx];
  assign expired  = elapsed >= {32'd0, sess_life};
  assign is_match = used[idx] && r.sid_present && (s_tok[idx] == r.sid);
  assign act_idx  = (r.req_type == REQ_AUTH) ? (is_match ? idx : last_idx)
                                             : (first_hit ? first_idx : idx);
  assign gsum     = {1'b0, r.now_ms} + {33'd0, grant_life};
  assign dprod    = {29'd0, rem} * {32'd0, MS_RECIP};

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_SRC_READY:  prdata = {31'd0, src_ready};
      REG_SESS_LIFE:  prdata = sess_life;
      REG_GRANT_LIFE: prdata = grant_life;
      default:        prdata = 32'd0;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data  = o;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_ready  <= 1'b0;
      sess_life  <= 32'd1800000;
      grant_life <= 32'd300000;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SRC_READY:  src_ready  <= pwdata[0];
        REG_SESS_LIFE:  sess_life  <= pwdata;
        REG_GRANT_LIFE: grant_life <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            r <= req.data;
            o <= '0;
            idx <= '0;
            first_hit <= 1'b0; last_hit <= 1'b0;
            free_hit <= 1'b0; old_valid <= 1'b0;
            first_idx <= '0; last_idx <= '0; free_idx <= '0; old_idx <= '0;
            old_time <= '0;
            live <= '0;
            match <= '0;
            state <= (req.data.req_type > REQ_QUERY) ? S_OUT : S_REAP;
          end
        end
        S_REAP: begin
          if (used[idx] && (s_epoch[idx] != r.epoch || expired))
            used[idx] <= 1'b0;
          if (idx == IW'(SLOT_COUNT - 1)) begin
            idx <= '0;
            state <= S_SRCH;
          end else idx <= idx + 1'b1;
        end
        S_SRCH: begin
          if (is_match) begin
            match[idx] <= 1'b1;
            last_hit <= 1'b1; last_idx <= idx;
            if (!first_hit) begin
              first_hit <= 1'b1; first_idx <= idx;
            end
          end
          if (used[idx]) live <= live + 1'b1;
          if (!used[idx] && !free_hit) begin
            free_hit <= 1'b1; free_idx <= idx;
          end
          if (!old_valid || s_created[idx] < old_time) begin
            old_valid <= 1'b1; old_idx <= idx; old_time <= s_created[idx];
          end
          if (idx == IW'(SLOT_COUNT - 1)) begin
            idx <= act_idx;
            state <= S_ACT;
          end else idx <= idx + 1'b1;
        end
        S_ACT: begin
          state <= S_OUT;
          case (r.req_type)
            REQ_CREATE: if (src_ready) begin
              used[free_hit ? free_idx : old_idx]      <= 1'b1;
              s_tok[free_hit ? free_idx : old_idx]     <= r.random_sid & TMASK;
              s_csrf[free_hit ? free_idx : old_idx]    <= r.random_csrf & TMASK;
              s_created[free_hit ? free_idx : old_idx] <= r.now_ms;
              s_grant[free_hit ? free_idx : old_idx]   <= '0;
              s_epoch[free_hit ? free_idx : old_idx]   <= r.epoch;
              o.success   <= 1'b1;
              o.token_out <= r.random_sid & TMASK;
              o.csrf_out  <= r.random_csrf & TMASK;
            end
            REQ_AUTH: begin
              if (!last_hit) o.gate_status <= GATE_NO_SESS;
              else if ((r.access_level == LVL_WRITE || r.access_level == LVL_UPDATE)
                       && !(r.csrf_present && r.csrf == s_csrf[idx]))
                o.gate_status <= GATE_BAD_CSRF;
              else if (r.access_level == LVL_UPDATE && !(r.now_ms < s_grant[idx]))
                o.gate_status <= GATE_NO_GRANT;
            end
            REQ_GRANT: if (first_hit) begin
              s_grant[idx] <= gsum[64] ? {64{1'b1}} : gsum[63:0];
              o.success <= 1'b1;
            end
            REQ_REVOKE: used <= used & ~match;
            REQ_RVKALL: used <= '0;
            REQ_QUERY: begin
              o.live_count <= 4'(live);
              if (first_hit) begin
                o.success      <= 1'b1;
                o.csrf_out     <= s_csrf[idx];
                o.grant_active <= r.now_ms < s_grant[idx];
                rem   <= sess_life - elapsed[31:0];
                state <= S_DIV;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          o.remaining_s <= dprod[60:38];
          state <= S_OUT;
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* tb/testbench.sv */
// Self-checking testbench for session_token_table_top: directed and random requests
// are scored against a slot-table predictor. Depends on stt_pkg, stt_req_if, stt_rsp_if.
`timescale 1ns / 1ps
module testbench;
  import stt_pkg::*;

  localparam int NSLOT = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1450;
  localparam int REQ_W = $bits(req_t);

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stt_req_if req_ch ();
  stt_rsp_if rsp_ch ();

  session_token_table_top dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic        src_ready;
  logic [31:0] sess_life;
  logic [31:0] grant_life;
  logic        s_used [NSLOT];
  logic [63:0] s_token [NSLOT];
  logic [63:0] s_csrf [NSLOT];
  logic [63:0] s_created [NSLOT];
  logic [63:0] s_grant [NSLOT];
  logic [31:0] s_epoch [NSLOT];

  rsp_t expected_rsp [$];
  int   mismatches;
  int   cycle_count;
  int   burst_left;
  int   hold_off;
  int   rx_mode;
  int   rx_left;

  // tokens handed out, reused as presented credentials
  logic [63:0] issued_sid [16];
  logic [63:0] issued_csrf [16];
  int          issued_n;
  logic [63:0] cur_now;
  logic [31:0] cur_epoch;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic void clear_slot(int i);
    s_used[i] = 1'b0;
    s_token[i] = '0;
    s_csrf[i] = '0;
    s_created[i] = '0;
    s_grant[i] = '0;
    s_epoch[i] = '0;
  endfunction

  function automatic bool_match(int i, req_t r);
    return s_used[i] && r.sid_present && s_token[i] == r.sid;
  endfunction

  function automatic rsp_t predict_session_rsp(req_t r);
    rsp_t o;
    int hit;
    logic [63:0] grant_end;
    logic [63:0] left;
    logic [3:0] n;
    o = '0;
    hit = -1;
    n = '0;
    if (r.req_type > REQ_QUERY) return o;
    for (int i = 0; i < NSLOT; i++)
      if (s_used[i] && (s_epoch[i] != r.epoch ||
          (r.now_ms - s_created[i]) >= {32'd0, sess_life}))
        clear_slot(i);
    case (r.req_type)
      REQ_CREATE: begin
        if (!src_ready) return o;
        for (int i = 0; i < NSLOT; i++)
          if (hit < 0 && !s_used[i]) hit = i;
        if (hit < 0) begin
          hit = 0;
          for (int i = 1; i < NSLOT; i++)
            if (s_created[i] < s_created[hit]) hit = i;
        end
        clear_slot(hit);
        s_used[hit] = 1'b1;
        s_token[hit] = r.random_sid;
        s_csrf[hit] = r.random_csrf;
        s_created[hit] = r.now_ms;
        s_epoch[hit] = r.epoch;
        o.success = 1'b1;
        o.token_out = r.random_sid;
        o.csrf_out = r.random_csrf;
      end
      REQ_AUTH: begin
        for (int i = 0; i < NSLOT; i++)
          if (bool_match(i, r)) hit = i;
        if (hit < 0)
          o.gate_status = GATE_NO_SESS;
        else if ((r.access_level == LVL_WRITE || r.access_level == LVL_UPDATE) &&
                 !(r.csrf_present && r.csrf == s_csrf[hit]))
          o.gate_status = GATE_BAD_CSRF;
        else if (r.access_level == LVL_UPDATE && !(r.now_ms < s_grant[hit]))
          o.gate_status = GATE_NO_GRANT;
        else
          o.gate_status = GATE_OK;
      end
      REQ_GRANT: begin
        for (int i = 0; i < NSLOT; i++)
          if (hit < 0 && bool_match(i, r)) hit = i;
        if (hit >= 0) begin
          grant_end = r.now_ms + {32'd0, grant_life};
          if (grant_end < r.now_ms) grant_end = '1;
          s_grant[hit] = grant_end;
          o.success = 1'b1;
        end
      end
      REQ_REVOKE: begin
        for (int i = 0; i < NSLOT; i++)
          if (bool_match(i, r)) clear_slot(i);
      end
      REQ_RVKALL: begin
        for (int i = 0; i < NSLOT; i++) clear_slot(i);
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (s_used[i]) n = n + 4'd1;
          if (hit < 0 && bool_match(i, r)) hit = i;
        end
        o.live_count = n;
        if (hit >= 0) begin
          left = {32'd0, sess_life} - (r.now_ms - s_created[hit]);
          o.success = 1'b1;
          o.csrf_out = s_csrf[hit];
          o.remaining_s = 23'(left / 64'd1000);
          o.grant_active = r.now_ms < s_grant[hit];
        end
      end
    endcase
    return o;
  endfunction

  // receiver: stall pattern plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(20, 150);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= $urandom_range(0, 1);
        default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic report(string field, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h actual %h", field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    rsp_t e;
    rsp_t a;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      a = rsp_ch.data;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: result transaction with none expected");
      end else begin
        e = expected_rsp.pop_front();
        report("success", e.success, a.success);
        report("gate_status", e.gate_status, a.gate_status);
        report("token_out", e.token_out, a.token_out);
        report("csrf_out", e.csrf_out, a.csrf_out);
        report("remaining_s", e.remaining_s, a.remaining_s);
        report("grant_active", e.grant_active, a.grant_active);
        report("live_count", e.live_count, a.live_count);
      end
    end
  end

  task automatic send_req(req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      repeat (gap) @(negedge clk) req_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_rsp.push_back(predict_session_rsp(r));
    if (r.req_type == REQ_CREATE && src_ready && r.req_type <= REQ_QUERY) begin
      issued_sid[issued_n % 16] = r.random_sid;
      issued_csrf[issued_n % 16] = r.random_csrf;
      issued_n++;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk) req_ch.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    wait_drained();
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SRC_READY: src_ready = value[0];
      REG_SESS_LIFE: sess_life = value;
      default: grant_life = value;
    endcase
  endtask

  task automatic set_regs(logic src, logic [31:0] life, logic [31:0] glife);
    write_reg(REG_SRC_READY, {31'd0, src});
    write_reg(REG_SESS_LIFE, life);
    write_reg(REG_GRANT_LIFE, glife);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t base_req(logic [2:0] kind, logic [63:0] now, logic [31:0] ep);
    req_t r;
    r = '0;
    r.req_type = kind;
    r.now_ms = now;
    r.epoch = ep;
    return r;
  endfunction

  function automatic req_t with_sid(req_t r, logic [63:0] sid, logic [63:0] csrf);
    r.sid_present = 1'b1;
    r.sid = sid;
    r.csrf_present = 1'b1;
    r.csrf = csrf;
    return r;
  endfunction

  task automatic test_reset_defaults();
    req_t r;
    r = base_req(REQ_CREATE, 64'd100, 32'd0);
    r.random_sid = 64'hAAAA;
    send_req(r);
    send_req(base_req(REQ_QUERY, 64'd100, 32'd0));
  endtask

  task automatic test_create_authorize();
    req_t r;
    write_reg(REG_SRC_READY, 32'd1);
    r = base_req(REQ_CREATE, 64'd1000, 32'd7);
    r.random_sid = '1;
    r.random_csrf = '1;
    send_req(r);
    r.random_sid = 64'h1;
    r.random_csrf = 64'h2;
    r.now_ms = 64'd2000;
    send_req(r);
    send_req(with_sid(base_req(REQ_QUERY, 64'd2500, 32'd7), 64'h1, 64'h2));
    r = with_sid(base_req(REQ_AUTH, 64'd3000, 32'd7), 64'h1, 64'h2);
    for (int lvl = 0; lvl < 4; lvl++) begin
      r.access_level = 2'(lvl);
      send_req(r);
    end
    r.csrf = 64'h3;
    r.access_level = LVL_WRITE;
    send_req(r);
    r.csrf = 64'h2;
    r.csrf_present = 1'b0;
    send_req(r);
    r.sid_present = 1'b0;
    send_req(r);
  endtask

  task automatic test_grant();
    req_t r;
    r = with_sid(base_req(REQ_GRANT, 64'd4000, 32'd7), 64'h1, 64'h2);
    send_req(r);
    r.req_type = REQ_AUTH;
    r.access_level = LVL_UPDATE;
    send_req(r);
    r.req_type = REQ_QUERY;
    send_req(r);
    r = with_sid(base_req(REQ_GRANT, 64'hFFFF_FFFF_FFFF_FF00, 32'd7), '1, '1);
    send_req(r);
  endtask

  task automatic test_revoke_evict();
    req_t r;
    send_req(base_req(REQ_RVKALL, 64'd10, 32'd7));
    for (int i = 0; i < 10; i++) begin
      r = base_req(REQ_CREATE, 64'd100 + 64'(i % 3), 32'd9);
      r.random_sid = 64'(i % 4 + 1);
      r.random_csrf = rand64();
      send_req(r);
    end
    send_req(with_sid(base_req(REQ_AUTH, 64'd200, 32'd9), 64'h2, 64'h0));
    send_req(with_sid(base_req(REQ_REVOKE, 64'd200, 32'd9), 64'h2, 64'h0));
    send_req(with_sid(base_req(REQ_QUERY, 64'd200, 32'd9), 64'h3, 64'h0));
    send_req(base_req(3'd6, 64'd200, 32'd1));
    send_req(base_req(3'd7, 64'd200, 32'd1));
    send_req(base_req(REQ_QUERY, 64'd200, 32'd10));
  endtask

  task automatic test_backpressure();
    req_t r;
    wait_drained();
    hold_off = 400;
    for (int i = 0; i < 6; i++) begin
      r = base_req(REQ_CREATE, cur_now, cur_epoch);
      r.random_sid = rand64();
      r.random_csrf = rand64();
      send_req(r);
    end
    wait_drained();
  endtask

  function automatic req_t random_req();
    req_t r;
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      r = REQ_W'({rand64(), rand64(), rand64(), rand64(), rand64(), rand64()});
      return r;
    end
    if ($urandom_range(0, 99) == 0) cur_epoch = $urandom;
    cur_now = cur_now + 64'($urandom_range(0, sess_life > 2000000 ? 2000000 : sess_life / 3 + 1));
    if (pick < 28) r = base_req(REQ_CREATE, cur_now, cur_epoch);
    else if (pick < 53) r = base_req(REQ_AUTH, cur_now, cur_epoch);
    else if (pick < 68) r = base_req(REQ_GRANT, cur_now, cur_epoch);
    else if (pick < 76) r = base_req(REQ_REVOKE, cur_now, cur_epoch);
    else if (pick < 78) r = base_req(REQ_RVKALL, cur_now, cur_epoch);
    else if (pick < 97) r = base_req(REQ_QUERY, cur_now, cur_epoch);
    else r = base_req(3'($urandom_range(6, 7)), cur_now, cur_epoch);
    if ($urandom_range(0, 19) == 0) r.epoch = $urandom;
    r.random_sid = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(1, 4)) : rand64();
    r.random_csrf = rand64();
    r.access_level = 2'($urandom_range(0, 3));
    k = (issued_n == 0) ? 0 : $urandom_range(0, (issued_n > 16 ? 16 : issued_n) - 1);
    r.sid_present = ($urandom_range(0, 15) != 0);
    r.sid = ($urandom_range(0, 9) < 8) ? issued_sid[k] : rand64();
    r.csrf_present = ($urandom_range(0, 15) != 0);
    r.csrf = ($urandom_range(0, 9) < 7) ? issued_csrf[k] : rand64();
    return r;
  endfunction

  task automatic test_random();
    int phase_items;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_regs(1'b1, 32'd1800000, 32'd300000);
        1: set_regs(1'b1, 32'd1, 32'd1);
        2: set_regs(1'b1, '1, '1);
        3: set_regs(1'b0, 32'd50000, 32'd20000);
        4: begin
          set_regs(1'b1, 32'd600000, 32'd100000);
          cur_now = 64'hFFFF_FFFF_FFF0_0000;
        end
        default: set_regs(1'b1, $urandom_range(1000, 5000000), $urandom);
      endcase
      phase_items = (phase == 1 || phase == 3) ? RANDOM_ITEMS / 12 : RANDOM_ITEMS / 5;
      for (int i = 0; i < phase_items; i++) send_req(random_req());
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    burst_left = 0;
    hold_off = 0;
    rx_mode = 0;
    rx_left = 0;
    issued_n = 0;
    cur_now = 64'd5000;
    cur_epoch = 32'd3;
    src_ready = 1'b0;
    sess_life = 32'd1800000;
    grant_life = 32'd300000;
    for (int i = 0; i < NSLOT; i++) clear_slot(i);
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_reset_defaults();
    test_create_authorize();
    test_grant();
    test_revoke_evict();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* files.f */
design/stt_pkg.sv
design/stt_req_if.sv
design/stt_rsp_if.sv
design/session_token_table_top.sv
tb/testbench.sv
